/* rtl/core/rfd_pkg.sv */
// Shared types and constants for the four-channel range frame decoder.
// No dependencies; used by every module in rtl/core.
package rfd_pkg;

    localparam int FRAME_BYTES   = 10;
    localparam int CHANNELS      = 4;
    localparam int PAYLOAD_BYTES = FRAME_BYTES - 2;
    localparam int POS_W         = $clog2(FRAME_BYTES);
    localparam int PEND_W        = $clog2(PAYLOAD_BYTES);
    localparam int DIST_W        = 16;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_NO_ECHO = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HEADER  = 2'd1;

    localparam logic [DIST_W-1:0] NO_ECHO_RESET = 16'd4000;
    localparam logic [7:0]        HEADER_RESET  = 8'hff;

    typedef logic [CHANNELS-1:0][DIST_W-1:0] t_dist_set;

    // one result word, flags in the low bits
    typedef struct packed {
        t_dist_set distances;
        logic      frame_short;
        logic      frame_good;
    } t_result;

endpackage

/* rtl/core/rfd_parser.sv */
// Input register plus per-byte frame tracking: position, checksum, header
// check, payload bytes and held distances. Depends on rfd_pkg.
module rfd_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [7:0]                  i_byte,
    input  logic                        i_timeout,
    output logic                        o_ready,
    input  logic [rfd_pkg::DIST_W-1:0]  i_no_echo,
    input  logic [7:0]                  i_header,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output rfd_pkg::t_result            o_res
);

    logic                             r_in_valid;
    logic [7:0]                       r_in_byte;
    logic                             r_in_timeout;
    logic [rfd_pkg::POS_W-1:0]        r_pos;
    logic [7:0]                       r_sum;
    logic                             r_hdr_ok;
    logic [rfd_pkg::PAYLOAD_BYTES-1:0][7:0] r_pend;
    rfd_pkg::t_dist_set               r_held;

    logic                             res_needed;
    logic                             step;
    logic                             good;
    logic [rfd_pkg::PEND_W-1:0]       pend_idx;
    rfd_pkg::t_dist_set               decoded;
    logic [rfd_pkg::DIST_W-1:0]       raw_d [rfd_pkg::CHANNELS];

    assign res_needed  = r_in_timeout || (r_pos == rfd_pkg::LAST_POS);
    assign step        = r_in_valid && (!res_needed || i_res_ready);
    assign o_ready     = !r_in_valid || step;
    assign o_res_valid = r_in_valid && res_needed;
    assign good        = !r_in_timeout && r_hdr_ok && (r_in_byte == r_sum);
    assign pend_idx    = rfd_pkg::PEND_W'(r_pos - rfd_pkg::POS_W'(1));

    // big-endian pairs, zero means no echo
    always_comb begin
        for (int c = 0; c < rfd_pkg::CHANNELS; c++) begin
            raw_d[c]   = {r_pend[2*c], r_pend[2*c+1]};
            decoded[c] = (raw_d[c] == '0) ? i_no_echo : raw_d[c];
        end
    end

    always_comb begin
        o_res.distances   = (good && (r_pos == rfd_pkg::LAST_POS)) ? decoded : r_held;
        o_res.frame_good  = good;
        o_res.frame_short = r_in_timeout;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte    <= i_byte;
            r_in_timeout <= i_timeout;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_sum    <= '0;
            r_hdr_ok <= 1'b0;
            r_held   <= '0;
        end else if (step) begin
            if (r_in_timeout || r_pos == rfd_pkg::LAST_POS) begin
                if (good) begin
                    r_held <= decoded;
                end
                r_pos    <= '0;
                r_sum    <= '0;
                r_hdr_ok <= 1'b0;
            end else begin
                if (r_pos == '0) begin
                    r_hdr_ok <= (r_in_byte == i_header);
                end
                r_sum <= r_sum + r_in_byte;
                r_pos <= r_pos + rfd_pkg::POS_W'(1);
            end
        end
    end

    // payload bytes, no reset: each is written before the checksum byte reads it
    always_ff @(posedge i_clk) begin
        if (step && !r_in_timeout && r_pos != '0 && r_pos != rfd_pkg::LAST_POS) begin
            r_pend[pend_idx] <= r_in_byte;
        end
    end

endmodule

/* rtl/core/rfd_out_reg.sv */
// Result register between the parser and the master-side stream.
// Depends on rfd_pkg.
module rfd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  rfd_pkg::t_result i_res,
    output logic             o_valid,
    input  logic             i_ready,
    output rfd_pkg::t_result o_res
);

    logic             r_valid;
    rfd_pkg::t_result r_res;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

endmodule

/* rtl/core/four_channel_range_frame_decoder.sv */
// Four-channel range frame decoder, top level.
// An accepted word's result reaches the master side through the input register,
// then the result register. Throughput: one word per cycle while the master side takes results.
// Synchronous active-low reset clears position, checksum, held distances and
// both valid flags; config registers return to 4000 and 0xff.
// Depends on rfd_pkg, rfd_parser and rfd_out_reg.
module four_channel_range_frame_decoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [7:0] rx_byte
    input  logic                             s_axis_tuser,  // [0] timeout_event
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [15:0] distance_ch0, [31:16] ch1, [47:32] ch2, [63:48] ch3
    output logic [63:0]                      m_axis_tdata,
    output logic [1:0]                       m_axis_tuser,  // [0] frame_good, [1] frame_short
    input  logic                             i_cfg_we,
    input  logic [rfd_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [rfd_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    logic [rfd_pkg::DIST_W-1:0] r_no_echo;
    logic [7:0]                 r_header;

    logic             res_valid;
    logic             res_ready;
    rfd_pkg::t_result res;
    rfd_pkg::t_result out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_no_echo <= rfd_pkg::NO_ECHO_RESET;
            r_header  <= rfd_pkg::HEADER_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rfd_pkg::CFG_NO_ECHO: r_no_echo <= i_cfg_wdata;
                rfd_pkg::CFG_HEADER:  r_header  <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    rfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .i_byte      (s_axis_tdata),
        .i_timeout   (s_axis_tuser),
        .o_ready     (s_axis_tready),
        .i_no_echo   (r_no_echo),
        .i_header    (r_header),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    rfd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (res_ready),
        .i_res   (res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tdata = out_res.distances;
    assign m_axis_tuser = {out_res.frame_short, out_res.frame_good};

endmodule

/* verif/four_channel_range_frame_decoder_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for four_channel_range_frame_decoder: random sensor byte streams
// and timeouts in, held distances and frame flags checked against an in-bench decoder.
// Depends on rfd_pkg and the decoder RTL only.
module four_channel_range_frame_decoder_tb;

    import rfd_pkg::*;

    localparam int DRAIN_CYCLES  = 8;     // result path is two registers deep
    localparam int HOLD_OFF      = 300;
    localparam int STALL_LIMIT   = 3000;  // cycles with no word moving on either side
    localparam int MAX_REPORTED  = 10;

    // indexes past the register list; the block must ignore writes to them
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_3 = 2'd3;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;   // [7:0] rx_byte
    logic                  s_axis_tuser  = 1'b0; // [0] timeout_event
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [63:0]           m_axis_tdata;         // [15:0] ch0 .. [63:48] ch3
    logic [1:0]            m_axis_tuser;         // [0] frame_good, [1] frame_short
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;

    four_channel_range_frame_decoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // Decoder mirror plus queue of distance reports still owed by the block.
    class range_frame_scoreboard;
        logic [DIST_W-1:0] no_echo_dist = NO_ECHO_RESET;
        logic [7:0]        header_byte  = HEADER_RESET;
        logic [POS_W-1:0]  group_pos    = '0;
        logic [7:0]        byte_sum     = '0;
        logic              header_ok    = 1'b0;
        logic [7:0]        payload [PAYLOAD_BYTES];
        t_dist_set         held         = '0;
        t_result           owed_reports [$];
        int                failures     = 0;
        int                results_seen = 0;
        int                good_seen    = 0;
        int                short_seen   = 0;

        function void set_register(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_NO_ECHO: no_echo_dist = data;
                CFG_HEADER:  header_byte  = data[7:0];
                default: ;
            endcase
        endfunction

        function void restart_group();
            group_pos = '0;
            byte_sum  = '0;
            header_ok = 1'b0;
        endfunction

        function void note_word(logic [7:0] rx_byte, logic timeout);
            t_result rep;
            logic [DIST_W-1:0] d;
            logic ok;
            if (timeout) begin
                restart_group();
                rep.distances   = held;
                rep.frame_good  = 1'b0;
                rep.frame_short = 1'b1;
                owed_reports.push_back(rep);
                return;
            end
            if (group_pos < LAST_POS) begin
                if (group_pos == 0)
                    header_ok = (rx_byte == header_byte);
                else
                    payload[group_pos - 1] = rx_byte;
                byte_sum  = byte_sum + rx_byte;
                group_pos = group_pos + 1'b1;
                return;
            end
            // checksum byte closes the group
            ok = header_ok && (rx_byte == byte_sum);
            if (ok) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    d = {payload[2*c], payload[2*c+1]};
                    held[c] = (d == 0) ? no_echo_dist : d;
                end
            end
            restart_group();
            rep.distances   = held;
            rep.frame_good  = ok;
            rep.frame_short = 1'b0;
            owed_reports.push_back(rep);
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= MAX_REPORTED)
                $display("mismatch at %0t: %s", $time, msg);
        endfunction

        function void check_word(logic [63:0] data, logic [1:0] flags);
            t_result   want;
            t_dist_set got;
            bit        bad;
            got = data;
            results_seen++;
            if (flags[0]) good_seen++;
            if (flags[1]) short_seen++;
            if (owed_reports.size() == 0) begin
                note_failure($sformatf("result %h flags %b with nothing owed", data, flags));
                return;
            end
            want = owed_reports.pop_front();
            bad  = (want.frame_good !== flags[0]) || (want.frame_short !== flags[1]);
            for (int c = 0; c < CHANNELS; c++)
                if (got[c] !== want.distances[c]) bad = 1'b1;
            if (bad)
                note_failure($sformatf(
                    {"result %0d expected ch %h %h %h %h good %b short %b, ",
                     "got ch %h %h %h %h good %b short %b"},
                    results_seen, want.distances[0], want.distances[1],
                    want.distances[2], want.distances[3],
                    want.frame_good, want.frame_short, got[0], got[1], got[2], got[3],
                    flags[0], flags[1]));
        endfunction
    endclass

    range_frame_scoreboard sb = new();

    bit src_pauses   = 1'b1;
    bit sink_pauses  = 1'b1;
    bit hold_off_req = 1'b0;
    int words_sent   = 0;
    int timeouts     = 0;
    int next_toggle  = 40;

    initial forever #2 i_clk = ~i_clk;

    function automatic int draw_gap(bit pauses);
        return pauses ? $urandom_range(0, 12) : 0;
    endfunction

    task automatic send_word(input logic [7:0] rx_byte, input logic timeout);
        int gap;
        gap = draw_gap(src_pauses);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx_byte;
        s_axis_tuser  <= timeout;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(rx_byte, timeout);
        words_sent++;
        if (timeout) timeouts++;
    endtask

    // cut < FRAME_BYTES sends that many bytes and then a timeout
    task automatic send_frame(input t_dist_set dists, input bit bad_header, input bit bad_sum,
                              input int cut);
        logic [7:0] fr [FRAME_BYTES];
        logic [7:0] s;
        fr[0] = sb.header_byte ^ (bad_header ? 8'($urandom_range(1, 255)) : 8'h00);
        for (int c = 0; c < CHANNELS; c++) begin
            fr[1+2*c] = dists[c][15:8];
            fr[2+2*c] = dists[c][7:0];
        end
        s = '0;
        for (int i = 0; i < FRAME_BYTES - 1; i++) s = s + fr[i];
        fr[FRAME_BYTES-1] = s + (bad_sum ? 8'($urandom_range(1, 255)) : 8'h00);
        for (int i = 0; i < cut && i < FRAME_BYTES; i++) send_word(fr[i], 1'b0);
        if (cut < FRAME_BYTES) send_word(8'($urandom), 1'b1);
    endtask

    function automatic t_dist_set random_dists();
        t_dist_set d;
        for (int c = 0; c < CHANNELS; c++)
            case ($urandom_range(0, 7))
                0:       d[c] = '0;                       // no echo
                1:       d[c] = 16'hffff;
                2:       d[c] = {8'h00, 8'($urandom)};
                default: d[c] = 16'($urandom);
            endcase
        return d;
    endfunction

    task automatic send_random_run(input int n);
        int target;
        int pick;
        int cut;
        target = words_sent + n;
        while (words_sent < target) begin
            if (words_sent >= next_toggle) begin
                src_pauses  = ($urandom_range(0, 2) != 0);
                sink_pauses = ($urandom_range(0, 2) != 0);
                next_toggle = words_sent + $urandom_range(20, 60);
            end
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                // realign first: abandon the partial group or pad it out
                if (sb.group_pos != 0) begin
                    if ($urandom_range(0, 1))
                        send_word(8'($urandom), 1'b1);
                    else
                        while (sb.group_pos != 0) send_word(8'($urandom), 1'b0);
                end
                cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, FRAME_BYTES - 1)
                                                  : FRAME_BYTES;
                send_frame(random_dists(), $urandom_range(0, 9) == 0,
                           $urandom_range(0, 9) == 0, cut);
            end else if (pick < 86) begin
                send_word(8'($urandom), 1'b1);
            end else begin
                repeat ($urandom_range(1, 12)) send_word(8'($urandom), 1'b0);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        sb.set_register(idx, data);
    endtask

    task automatic program_regs(input logic [15:0] no_echo, input logic [15:0] header_word,
                                input bit poke_spare);
        write_reg(CFG_NO_ECHO, no_echo);
        write_reg(CFG_HEADER, header_word);
        if (poke_spare) begin
            write_reg(CFG_SPARE_2, 16'($urandom));
            write_reg(CFG_SPARE_3, 16'($urandom));
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.owed_reports.size() != 0) @(posedge i_clk);
        // a trailing mid-group byte may still sit in the pipe
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : result_sink
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_off_req) begin
                stall        = HOLD_OFF;
                hold_off_req = 1'b0;
            end else begin
                stall = draw_gap(sink_pauses);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_word(m_axis_tdata, m_axis_tuser);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("[four_channel_range_frame_decoder] ERROR");
        $finish;
    end

    initial begin : stimulus
        t_dist_set d;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset register values: zero, max, min and top-bit distances in one good frame
        d[0] = 16'h0000;
        d[1] = 16'hffff;
        d[2] = 16'h0001;
        d[3] = 16'h8000;
        send_frame(d, 1'b0, 1'b0, FRAME_BYTES);
        send_word(8'h5a, 1'b1);                  // timeout on an empty group
        send_frame(d, 1'b0, 1'b0, 4);            // partial group abandoned
        d[0] = 16'h1234;
        d[1] = 16'h0000;
        d[2] = 16'h00ff;
        d[3] = 16'hff00;
        send_frame(d, 1'b0, 1'b1, FRAME_BYTES);  // bad checksum keeps old distances

        wait_drained();
        program_regs(16'h0000, {8'($urandom), 8'h00}, 1'b0);
        send_random_run(150);

        // full-scale substitute; sink holds off while timeouts pile into the pipe
        wait_drained();
        program_regs(16'hffff, {8'($urandom), 8'hff}, 1'b1);
        src_pauses   = 1'b0;
        hold_off_req = 1'b1;
        repeat (24) send_word(8'($urandom), 1'b1);
        send_random_run(130);

        wait_drained();
        program_regs(16'($urandom), 16'($urandom), 1'b0);
        send_random_run(160);

        wait_drained();
        program_regs(16'($urandom_range(1, 4000)), 16'($urandom), 1'b1);
        send_random_run(150);

        wait_drained();
        if (sb.owed_reports.size() != 0)
            sb.note_failure($sformatf("%0d results never arrived", sb.owed_reports.size()));
        $display("sent %0d sensor bytes and timeouts (%0d timeouts) over five register settings",
                 words_sent, timeouts);
        $display("checked %0d results: %0d good frames, %0d short groups, %0d failures",
                 sb.results_seen, sb.good_seen, sb.short_seen, sb.failures);
        if (sb.failures == 0)
            $display("[four_channel_range_frame_decoder] OK");
        else
            $display("[four_channel_range_frame_decoder] ERROR");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/rfd_pkg.sv
rtl/core/rfd_parser.sv
rtl/core/rfd_out_reg.sv
rtl/core/four_channel_range_frame_decoder.sv
verif/four_channel_range_frame_decoder_tb.sv
